// ===== hdl/tsd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the temperature settle detector
// Item layouts, event and phase codes, register indexes and the streak limit.
// ---------------------------------------------------------------------------
package tsd_pkg;

   // Number of consecutive in-window temperatures needed to leave wait.
   localparam int HISTORY_DEPTH = 128;
   localparam int STREAK_W      = $clog2(HISTORY_DEPTH + 1);
   localparam logic [STREAK_W-1:0] STREAK_FULL = STREAK_W'(HISTORY_DEPTH);

   localparam int TEMP_W  = 20;
   localparam int HALF_W  = 16;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 3;

   // Reset value of the window half width: 0.25 K in 1/256 K units.
   localparam logic [HALF_W-1:0] WINDOW_RESET = HALF_W'(64);

   // Event codes.
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_STOP   = 2'd2;

   // Phase codes as reported in a result item.
   localparam logic [1:0] PHASE_RAMP = 2'd0;
   localparam logic [1:0] PHASE_WAIT = 2'd1;
   localparam logic [1:0] PHASE_TEST = 2'd2;
   localparam logic [1:0] PHASE_IDLE = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SETPOINT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HALF_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENABLED      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TIME_MS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TIME_MS    = 3'd4;

   typedef enum logic [3:0] {
      ST_RAMP = 4'b0001,
      ST_WAIT = 4'b0010,
      ST_TEST = 4'b0100,
      ST_IDLE = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [TEMP_W-1:0] temperature;
      logic [TEMP_W-1:0] current_setpoint;
      logic [TIME_W-1:0] elapsed_ms;
      logic              ramp_done;
   } req_item_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       settled;
      logic       stopped;
   } rsp_item_type;

   typedef struct packed {
      logic [TEMP_W-1:0] target_setpoint;
      logic [HALF_W-1:0] window_half_width;
      logic              ramp_enabled;
      logic [TIME_W-1:0] ramp_time_ms;
      logic [TIME_W-1:0] settle_time_ms;
   } cfg_type;

   function automatic logic [1:0] phase_code(input seq_state_type st);
      logic [1:0] code;
      unique case (st)
         ST_RAMP: code = PHASE_RAMP;
         ST_WAIT: code = PHASE_WAIT;
         ST_TEST: code = PHASE_TEST;
         default: code = PHASE_IDLE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/tsd_window.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsd_window: window compare
// Flags a temperature whose distance from a center is at most the half width.
// ---------------------------------------------------------------------------
module tsd_window (
   input  wire logic [tsd_pkg::TEMP_W-1:0] value,
   input  wire logic [tsd_pkg::TEMP_W-1:0] center,
   input  wire logic [tsd_pkg::HALF_W-1:0] half_width,
   output logic                            hit
);
   import tsd_pkg::*;

   logic [TEMP_W-1:0] distance;

   assign distance = (value >= center) ? (value - center) : (center - value);
   assign hit      = (distance <= TEMP_W'(half_width));

endmodule
`default_nettype wire

// ===== hdl/tsd_sequencer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tsd_sequencer: ramp, wait and test phase sequencer
// Holds the phase, the in-window streak and the test start time, and forms
// the result of each accepted item in the same cycle.
// ---------------------------------------------------------------------------
module tsd_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire tsd_pkg::req_item_type item,
   input  wire tsd_pkg::cfg_type      cfg,
   output tsd_pkg::rsp_item_type      result
);
   import tsd_pkg::*;

   seq_state_type       phase_ff, phase_in;
   logic [STREAK_W-1:0] streak_ff, streak_in;
   logic [TIME_W-1:0]   test_start_ff, test_start_in;

   logic                target_hit;
   logic                setpoint_hit;
   logic [STREAK_W-1:0] streak_counted;
   logic [TIME_W-1:0]   time_in_test;
   logic                settled;
   logic                stopped;

   tsd_window u_target_window (
      .value      (item.temperature),
      .center     (cfg.target_setpoint),
      .half_width (cfg.window_half_width),
      .hit        (target_hit)
   );

   tsd_window u_setpoint_window (
      .value      (item.temperature),
      .center     (item.current_setpoint),
      .half_width (cfg.window_half_width),
      .hit        (setpoint_hit)
   );

   assign time_in_test = item.elapsed_ms - test_start_ff;

   always_comb begin
      if (!target_hit) begin
         streak_counted = '0;
      end else if (streak_ff < STREAK_FULL) begin
         streak_counted = streak_ff + STREAK_W'(1);
      end else begin
         streak_counted = streak_ff;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      streak_in     = streak_ff;
      test_start_in = test_start_ff;
      settled       = 1'b0;
      stopped       = 1'b0;
      if (accept) begin
         unique case (item.func)
            FUNC_START: begin
               // The temperature at start counts as the first of a new streak.
               streak_in = target_hit ? STREAK_W'(1) : '0;
               phase_in  = cfg.ramp_enabled ? ST_RAMP : ST_WAIT;
            end
            FUNC_STOP: begin
               if (phase_ff != ST_IDLE) begin
                  phase_in = ST_IDLE;
                  stopped  = 1'b1;
               end
            end
            FUNC_SAMPLE: begin
               if (phase_ff != ST_IDLE) begin
                  streak_in = streak_counted;
                  unique case (phase_ff)
                     ST_RAMP: begin
                        if ((item.elapsed_ms > cfg.ramp_time_ms) && item.ramp_done) begin
                           phase_in = ST_WAIT;
                        end
                     end
                     ST_WAIT: begin
                        if (streak_counted >= STREAK_FULL) begin
                           test_start_in = item.elapsed_ms;
                           phase_in      = ST_TEST;
                        end
                     end
                     ST_TEST: begin
                        if (!setpoint_hit) begin
                           phase_in = ST_WAIT;
                        end else if (time_in_test >= cfg.settle_time_ms) begin
                           phase_in = ST_IDLE;
                           settled  = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign result.phase   = phase_code(phase_in);
   assign result.settled = settled;
   assign result.stopped = stopped;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ST_IDLE;
         streak_ff     <= '0;
         test_start_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         streak_ff     <= streak_in;
         test_start_ff <= test_start_in;
      end
   end

`ifndef SYNTHESIS
   a_streak_bounded: assert property (@(posedge clock) disable iff (reset)
      streak_ff <= STREAK_FULL)
      else $error("in-window streak ran past its limit");

   a_stop_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (item.func == FUNC_STOP)) |=> (phase_ff == ST_IDLE))
      else $error("stop event did not leave the sequencer idle");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (accept && (item.func == FUNC_START))
         |=> ((phase_ff == ST_RAMP) || (phase_ff == ST_WAIT)))
      else $error("start event did not begin a run");
`endif

endmodule
`default_nettype wire

// ===== hdl/temperature_settle_detector_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// temperature_settle_detector_unit: settle detector for a controlled temperature
// Register file, phase sequencer and registered result channel.
// ---------------------------------------------------------------------------
// Each request item is an event (sample, start run or stop run) and produces
// exactly one response item carrying the phase after that event and the
// settled and stopped pulses. The block takes one item per cycle: the whole
// decision for an item is made in one pass of window compares, a streak
// counter and a 32-bit time compare, between the sequencer state registers
// and the response register, so a valid response appears in the cycle after
// acceptance. The response register alone decouples the two
// channels; req_stall is raised only while a response is waiting and the
// response side stalls, and while reset is held. Registers are written
// through the csr_ port and should be changed only while no run is expected
// to react to them; writes to indexes beyond the register list are ignored.
// ---------------------------------------------------------------------------
module temperature_settle_detector_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tsd_pkg::req_item_type           req_item,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tsd_pkg::rsp_item_type                rsp_item,

   input  wire logic                            csr_write_enable,
   input  wire logic [tsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tsd_pkg::CSR_W-1:0]       csr_write_data
);
   import tsd_pkg::*;

   cfg_type      cfg_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         req_accept;

   // Configuration registers. Each write takes the low bits of the data word.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_setpoint   <= '0;
         cfg_ff.window_half_width <= WINDOW_RESET;
         cfg_ff.ramp_enabled      <= 1'b0;
         cfg_ff.ramp_time_ms      <= '0;
         cfg_ff.settle_time_ms    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_SETPOINT:   cfg_ff.target_setpoint   <= csr_write_data[TEMP_W-1:0];
            CSR_WINDOW_HALF_WIDTH: cfg_ff.window_half_width <= csr_write_data[HALF_W-1:0];
            CSR_RAMP_ENABLED:      cfg_ff.ramp_enabled      <= csr_write_data[0];
            CSR_RAMP_TIME_MS:      cfg_ff.ramp_time_ms      <= csr_write_data[TIME_W-1:0];
            CSR_SETTLE_TIME_MS:    cfg_ff.settle_time_ms    <= csr_write_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A new item is taken whenever the response register is free or drains now.
   assign req_stall  = reset || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   tsd_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (req_item),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload register needs no reset; it is loaded with every accepted item.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item did not produce a response");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.settled && rsp_item.stopped))
      else $error("settled and stopped raised together");

   a_pulse_means_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.settled || rsp_item.stopped)) |-> (rsp_item.phase == PHASE_IDLE))
      else $error("run ended without reporting idle");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the temperature settle detector
// Drives start, sample and stop events through the request channel, predicts
// each response from an independent sequencer model kept in the testbench,
// and compares every response field by field under random sender gaps and
// random receiver stalls.
// ---------------------------------------------------------------------------
module tb;
   import tsd_pkg::*;

   // Index past the end of the register list; the block must ignore it.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   // Event code that has no meaning; the block must ignore the item.
   localparam logic [1:0]        FUNC_UNUSED = 2'd3;
   localparam logic [TEMP_W-1:0] TEMP_MAX    = '1;
   localparam logic [TIME_W-1:0] TIME_MAX    = '1;
   localparam int DRAIN_LIMIT = 5000;
   localparam int PRINT_LIMIT = 40;
   localparam int RUN_LIMIT   = 20 * 400000;
   localparam int EXPECT_DEPTH = 256;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_BEAT,
      STALL_HEAVY
   } stall_style_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // Shadow copy of the register file, updated as each write is issued.
   logic [TEMP_W-1:0] cur_target;
   logic [HALF_W-1:0] cur_half;
   logic              cur_ramp_en;
   logic [TIME_W-1:0] cur_ramp_ms;
   logic [TIME_W-1:0] cur_settle_ms;

   // Sequencer state as the testbench believes it to be.
   logic [1:0]        seq_phase;
   logic [7:0]        streak;
   logic [TIME_W-1:0] test_entry_ms;

   // Responses predicted for accepted items, kept in a ring in arrival order.
   // The running totals of stored and checked items give the ring positions.
   rsp_item_type expected_status[EXPECT_DEPTH];
   int unsigned  expect_wr_total = 0;
   int unsigned  expect_rd_total = 0;
   int mismatches = 0;
   int burst_left = 0;

   stall_style_type stall_mode = STALL_NONE;
   logic [7:0]      stall_clock = '0;

   temperature_settle_detector_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #(RUN_LIMIT);
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   // Number of predicted responses that have not been checked yet.
   function automatic int unsigned pending_count();
      return expect_wr_total - expect_rd_total;
   endfunction

   // ------------------------------------------------------------------------
   // Sequencer prediction
   // ------------------------------------------------------------------------

   // A temperature is inside a window when its distance from the center is
   // no more than the half width; the boundary itself counts as inside.
   function automatic bit near_window(input logic [TEMP_W-1:0] t,
                                      input logic [TEMP_W-1:0] center);
      logic [TEMP_W-1:0] gap;
      gap = (t >= center) ? t - center : center - t;
      return gap <= cur_half;
   endfunction

   // Counts one temperature against the target window. The streak stops
   // growing once it reaches the history depth.
   function automatic void tally_temperature(input logic [TEMP_W-1:0] t);
      if (near_window(t, cur_target)) begin
         if (streak < HISTORY_DEPTH) begin
            streak = streak + 8'd1;
         end
      end else begin
         streak = '0;
      end
   endfunction

   // Applies one event to the predicted state and returns the response that
   // the block must give for it.
   function automatic rsp_item_type advance_sequencer(input req_item_type ev);
      rsp_item_type res;
      res = '0;
      case (ev.func)
         FUNC_START: begin
            // A start restarts any run; no phase check on this event.
            streak = '0;
            tally_temperature(ev.temperature);
            seq_phase = cur_ramp_en ? PHASE_RAMP : PHASE_WAIT;
         end
         FUNC_STOP: begin
            if (seq_phase != PHASE_IDLE) begin
               seq_phase = PHASE_IDLE;
               res.stopped = 1'b1;
            end
         end
         FUNC_SAMPLE: begin
            if (seq_phase != PHASE_IDLE) begin
               // The streak is updated in every running phase before the
               // phase decision is made.
               tally_temperature(ev.temperature);
               case (seq_phase)
                  PHASE_RAMP: begin
                     if (ev.elapsed_ms > cur_ramp_ms && ev.ramp_done) begin
                        seq_phase = PHASE_WAIT;
                     end
                  end
                  PHASE_WAIT: begin
                     if (streak >= HISTORY_DEPTH) begin
                        test_entry_ms = ev.elapsed_ms;
                        seq_phase = PHASE_TEST;
                     end
                  end
                  default: begin
                     // Time in test wraps as a 32-bit difference.
                     if (!near_window(ev.temperature, ev.current_setpoint)) begin
                        seq_phase = PHASE_WAIT;
                     end else if (ev.elapsed_ms - test_entry_ms >= cur_settle_ms) begin
                        seq_phase = PHASE_IDLE;
                        res.settled = 1'b1;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
      res.phase = seq_phase;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_item_type make_event(input logic [1:0]        func,
                                               input logic [TEMP_W-1:0] temp,
                                               input logic [TEMP_W-1:0] csetp,
                                               input logic [TIME_W-1:0] ms,
                                               input logic              rdone);
      req_item_type ev;
      ev.func = func;
      ev.temperature = temp;
      ev.current_setpoint = csetp;
      ev.elapsed_ms = ms;
      ev.ramp_done = rdone;
      return ev;
   endfunction

   // Picks a temperature inside or outside the window around a center. The
   // window edge and the first value past it are chosen often on purpose.
   function automatic logic [TEMP_W-1:0] pick_temperature(input logic [TEMP_W-1:0] center,
                                                          input bit in_window);
      int unsigned c;
      int unsigned d;
      c = center;
      if (in_window) begin
         d = ($urandom_range(0, 3) == 0) ? cur_half : $urandom_range(0, cur_half);
         if ($urandom_range(0, 1) == 1) begin
            return (c + d > TEMP_MAX) ? TEMP_MAX : TEMP_W'(c + d);
         end
         return (c >= d) ? TEMP_W'(c - d) : '0;
      end
      d = cur_half + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
      return (c >= d) ? TEMP_W'(c - d) : TEMP_W'(c + d);
   endfunction

   // Offers one item, waits until it is taken, records the expected response
   // and then either keeps the burst going or leaves a random gap. The valid
   // is never dropped at the step where the next item is offered.
   task automatic send_event(input req_item_type ev);
      req_valid <= 1'b1;
      req_item <= ev;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_status[expect_wr_total[7:0]] = advance_sequencer(ev);
      expect_wr_total++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Pauses the sender until every predicted response has come back, then
   // leaves the response register time to empty.
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_count() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_count() != 0) begin
         report_mismatch($sformatf("%0d expected responses never arrived",
                                   pending_count()));
         expect_rd_total = expect_wr_total;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0]     data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_TARGET_SETPOINT:   cur_target = data[TEMP_W-1:0];
         CSR_WINDOW_HALF_WIDTH: cur_half = data[HALF_W-1:0];
         CSR_RAMP_ENABLED:      cur_ramp_en = data[0];
         CSR_RAMP_TIME_MS:      cur_ramp_ms = data[TIME_W-1:0];
         CSR_SETTLE_TIME_MS:    cur_settle_ms = data[TIME_W-1:0];
         default: ;
      endcase
   endtask

   // Reprograms all registers while the block is idle. A write to an unused
   // index comes last so that any aliasing would corrupt a live setting.
   task automatic apply_settings(input logic [TEMP_W-1:0] target,
                                 input logic [HALF_W-1:0] half,
                                 input logic              ramp_en,
                                 input logic [TIME_W-1:0] ramp_ms,
                                 input logic [TIME_W-1:0] settle_ms);
      wait_for_results();
      write_register(CSR_TARGET_SETPOINT, CSR_W'(target));
      write_register(CSR_WINDOW_HALF_WIDTH, CSR_W'(half));
      write_register(CSR_RAMP_ENABLED, CSR_W'(ramp_en));
      write_register(CSR_RAMP_TIME_MS, CSR_W'(ramp_ms));
      write_register(CSR_SETTLE_TIME_MS, CSR_W'(settle_ms));
      write_register(CSR_UNUSED, $urandom);
      csr_write_enable <= 1'b0;
   endtask

   // One well-formed run: a start, then samples whose content is steered by
   // the predicted phase so that the run gets through ramp, builds a full
   // streak in wait and spends time in test. Rare misses, restarts and
   // unused codes are mixed in. The run ends on settle or length, and is
   // usually closed by a stop.
   task automatic run_sequence(input int          max_len,
                               input logic [TIME_W-1:0] first_ms,
                               input int unsigned max_step,
                               input int unsigned done_odds,
                               input int unsigned miss_odds);
      logic [TIME_W-1:0] ms;
      logic [TEMP_W-1:0] csetp;
      logic [1:0]        func;
      logic              rdone;
      bit                in_window;
      int                n;
      int unsigned       pick;
      ms = first_ms;
      send_event(make_event(FUNC_START,
                            pick_temperature(cur_target, $urandom_range(0, 9) != 0),
                            cur_target, ms, 1'b0));
      n = 0;
      while (n < max_len && seq_phase != PHASE_IDLE) begin
         ms += $urandom_range(0, max_step);
         csetp = cur_target;
         rdone = 1'($urandom_range(0, 1));
         case (seq_phase)
            PHASE_RAMP: begin
               in_window = $urandom_range(0, 19) != 0;
               rdone = $urandom_range(1, done_odds) == 1;
               // Landing exactly on the ramp time must not end the ramp.
               if ($urandom_range(0, 15) == 0) begin
                  ms = cur_ramp_ms;
               end
            end
            PHASE_WAIT: begin
               in_window = (miss_odds == 0) || ($urandom_range(1, miss_odds) != 1);
            end
            default: begin
               in_window = $urandom_range(0, 39) != 0;
               // A controller setpoint off the target can put an in-target
               // sample outside its own window.
               if ($urandom_range(0, 3) == 0) begin
                  csetp = pick_temperature(cur_target, 1'b1);
               end
               // Jump to one short of, or exactly at, the settle deadline.
               if ($urandom_range(0, 24) == 0) begin
                  ms = test_entry_ms + cur_settle_ms - $urandom_range(0, 1);
               end
            end
         endcase
         pick = $urandom_range(0, 199);
         if (pick == 0) begin
            func = FUNC_START;
         end else if (pick < 3) begin
            func = FUNC_UNUSED;
         end else begin
            func = FUNC_SAMPLE;
         end
         send_event(make_event(func, pick_temperature(cur_target, in_window), csetp, ms,
                               rdone));
         n++;
      end
      if (seq_phase != PHASE_IDLE || $urandom_range(0, 3) == 0) begin
         send_event(make_event(FUNC_STOP, TEMP_W'($urandom), TEMP_W'($urandom), $urandom,
                               1'($urandom)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // With the reset settings: samples, stops and unused codes while idle
   // must all be ignored, at both extremes of every field.
   task automatic test_idle_events();
      send_event(make_event(FUNC_SAMPLE, TEMP_MAX, TEMP_MAX, TIME_MAX, 1'b1));
      send_event(make_event(FUNC_SAMPLE, '0, '0, '0, 1'b0));
      send_event(make_event(FUNC_STOP, TEMP_MAX, '0, TIME_MAX, 1'b1));
      send_event(make_event(FUNC_UNUSED, '0, TEMP_MAX, '0, 1'b0));
   endtask

   // Starting, restarting and stopping a run. The reset window is 64 around
   // a target of zero, so 64 sits on the edge and 65 lies just outside.
   task automatic test_run_control();
      send_event(make_event(FUNC_START, 20'd64, '0, '0, 1'b0));
      send_event(make_event(FUNC_UNUSED, 20'd64, '0, 32'd5, 1'b0));
      send_event(make_event(FUNC_SAMPLE, 20'd65, '0, 32'd10, 1'b1));
      send_event(make_event(FUNC_START, 20'd65, '0, 32'd20, 1'b0));
      send_event(make_event(FUNC_STOP, '0, '0, 32'd30, 1'b0));
      send_event(make_event(FUNC_STOP, '0, '0, 32'd40, 1'b0));
   endtask

   // The ramp ends only when the elapsed time is strictly past the ramp time
   // and the ramp-done flag is set. Also covers the narrowest and widest
   // windows and the largest ramp time, which can never be passed.
   task automatic test_ramp_exit();
      apply_settings(TEMP_MAX, '0, 1'b1, 32'd1000, TIME_MAX);
      send_event(make_event(FUNC_START, TEMP_MAX, TEMP_MAX, '0, 1'b0));
      send_event(make_event(FUNC_SAMPLE, TEMP_MAX, TEMP_MAX, 32'd1000, 1'b1));
      send_event(make_event(FUNC_SAMPLE, TEMP_MAX, TEMP_MAX, 32'd1001, 1'b0));
      send_event(make_event(FUNC_SAMPLE, TEMP_MAX, TEMP_MAX, 32'd1001, 1'b1));
      send_event(make_event(FUNC_SAMPLE, TEMP_MAX - 20'd1, TEMP_MAX, 32'd1002, 1'b1));
      send_event(make_event(FUNC_START, '0, '0, 32'd1003, 1'b1));
      send_event(make_event(FUNC_STOP, '0, '0, 32'd1004, 1'b0));

      apply_settings('0, '1, 1'b1, TIME_MAX, '0);
      send_event(make_event(FUNC_START, 20'd65535, '0, '0, 1'b0));
      send_event(make_event(FUNC_SAMPLE, 20'd65536, '0, TIME_MAX, 1'b1));
      send_event(make_event(FUNC_STOP, '0, '0, TIME_MAX, 1'b1));
   endtask

   // Complete runs under a range of settings, including zero and full-scale
   // targets and windows, a settle time of zero, a ramp that can never end,
   // the largest settle time, and elapsed times that wrap around.
   task automatic test_settle_runs();
      for (int k = 0; k < 6; k++) begin
         case (k)
            0: begin
               apply_settings(TEMP_W'($urandom_range(0, TEMP_MAX)), WINDOW_RESET, 1'b1,
                              32'd300, 32'd200);
               run_sequence(240, '0, 20, 4, 0);
            end
            1: begin
               apply_settings('0, '0, 1'b0, $urandom, '0);
               run_sequence(200, $urandom, 50, 4, 300);
            end
            2: begin
               apply_settings(TEMP_MAX, '1, 1'b1, '0, 32'd600);
               run_sequence(260, TIME_MAX - $urandom_range(0, 2000), 20, 3, 0);
            end
            3: begin
               apply_settings(TEMP_W'($urandom_range(0, TEMP_MAX)),
                              HALF_W'($urandom_range(1, 2000)), 1'b1,
                              TIME_MAX, $urandom_range(0, 50));
               run_sequence(40, $urandom, 1000, 1, 0);
            end
            4: begin
               apply_settings(TEMP_W'($urandom_range(0, TEMP_MAX)), HALF_W'($urandom), 1'b0,
                              $urandom, TIME_MAX);
               run_sequence(200, $urandom, 100, 2, 400);
            end
            default: begin
               apply_settings(TEMP_W'($urandom_range(0, TEMP_MAX)),
                              HALF_W'($urandom_range(0, 4000)), 1'b1,
                              $urandom_range(0, 500), $urandom_range(0, 400));
               run_sequence(240, '0, 20, 4, 0);
            end
         endcase
      end
   endtask

   // Unstructured items with every field random, occasionally starting a
   // run so that stray events also land on a running sequencer.
   task automatic test_random_noise();
      for (int i = 0; i < 80; i++) begin
         send_event(make_event(2'($urandom_range(0, 3)), TEMP_W'($urandom),
                               TEMP_W'($urandom), $urandom, 1'($urandom)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Response checking and receiver stalls
   // ------------------------------------------------------------------------

   // Each accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_count() == 0) begin
            report_mismatch($sformatf("unexpected response, phase %0d", rsp_item.phase));
         end else begin
            want = expected_status[expect_rd_total[7:0]];
            expect_rd_total++;
            if (rsp_item.phase !== want.phase) begin
               report_mismatch($sformatf("phase %0d, expected %0d",
                                         rsp_item.phase, want.phase));
            end
            if (rsp_item.settled !== want.settled) begin
               report_mismatch($sformatf("settled %b, expected %b",
                                         rsp_item.settled, want.settled));
            end
            if (rsp_item.stopped !== want.stopped) begin
               report_mismatch($sformatf("stopped %b, expected %b",
                                         rsp_item.stopped, want.stopped));
            end
         end
      end
   end

   // The receiver changes its stall style whenever stall_clock[5:0] wraps: no
   // stalls, light random stalls, a regular beat, or heavy random stalls.
   always @(posedge clock) begin
      stall_clock <= stall_clock + 8'd1;
      if (stall_clock[5:0] == 6'h3f) begin
         stall_mode <= stall_style_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_BEAT:  rsp_stall <= stall_clock[2];
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      // The predictor starts from the reset state of the block.
      cur_target = '0;
      cur_half = WINDOW_RESET;
      cur_ramp_en = 1'b0;
      cur_ramp_ms = '0;
      cur_settle_ms = '0;
      seq_phase = PHASE_IDLE;
      streak = '0;
      test_entry_ms = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_idle_events();
      test_run_control();
      test_ramp_exit();
      test_settle_runs();
      test_random_noise();

      wait_for_results();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
